FILE: src/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared codes for the segmented memory manager: commands, result status
// and sequencer states.
// ----------------------------------------------------------------------------
package smm_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD    = 3'd0,
    CMD_STORE   = 3'd1,
    CMD_MAP     = 3'd2,
    CMD_UNMAP   = 3'd3,
    CMD_REPLACE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_NO_ID = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_COPY
  } state_e;

endpackage

FILE: src/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int              WIDTH = 32,
  parameter longint unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/segmented_memory_manager.sv
// ----------------------------------------------------------------------------
// segmented_memory_manager
// Segmented word memory with load, store, map, unmap and replace requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (in_valid_i / in_ready_o) and each one
//   yields exactly one result transfer on the out channel (out_valid_o /
//   out_ready_i), in request order.
//   The transfer cycle of a request issues the reads of the word, length
//   and free-stack memories; the execute state then checks, writes back
//   and posts the result. Map further holds the block while it zero-fills
//   the segment one word per cycle; replace holds it while it copies one
//   word per cycle through the single read port of the word memory. No
//   new request is taken until the current one has returned to idle.
//   The result leaves through an output register, so the next request is
//   taken while a result still waits; a stalled receiver holds the result
//   and stalls only the request behind it, before any of its side effects.
//   After reset the block sweeps the length memory to zero, one entry per
//   cycle, with in_ready_o low. Counters of issued and freed IDs reset to
//   zero; word and free-stack contents start undefined and their values are
//   only used after being written.
// ----------------------------------------------------------------------------
module segmented_memory_manager
  import smm_pkg::*;
#(
  parameter int SEGMENT_COUNT = 64,
  parameter int SEGMENT_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [5:0]  segment_id_i,
  input  logic [8:0]  word_offset_i,
  input  logic [31:0] store_value_i,
  input  logic [8:0]  map_words_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_word_o,
  output logic [5:0]  mapped_id_o,
  output logic [1:0]  status_o
);

  // Storage geometry
  localparam longint unsigned WordDepth =
    longint'(SEGMENT_COUNT) * longint'(SEGMENT_WORDS);
  localparam int AW    = $clog2(WordDepth);            // word address
  localparam int SEG_W = $clog2(SEGMENT_COUNT);        // segment index
  localparam int CNT_W = $clog2(SEGMENT_COUNT + 1);    // ID counters
  localparam int LEN_W = $clog2(SEGMENT_WORDS + 1);    // segment length

  // Sequencer and request registers
  state_e             state_q, state_d;
  logic [SEG_W-1:0]   clr_idx_q, clr_idx_d;
  logic [2:0]         cmd_q;
  logic [5:0]         seg_q;
  logic [8:0]         off_q;
  logic [31:0]        val_q;
  logic [8:0]         words_q;
  logic [AW-1:0]      addr_q;
  logic [CNT_W-1:0]   free_cnt_q, free_cnt_d;
  logic [CNT_W-1:0]   issued_q, issued_d;
  logic [AW-1:0]      base_q, base_d;
  logic [LEN_W-1:0]   idx_q, idx_d;
  logic [LEN_W-1:0]   n_q, n_d;
  logic               pend_q, pend_d;
  logic [LEN_W-1:0]   pend_idx_q, pend_idx_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [31:0]        read_word_q, read_word_d;
  logic [5:0]         mapped_id_q, mapped_id_d;
  status_e            status_q, status_d;

  // Memory ports
  logic               word_we, word_re;
  logic [AW-1:0]      word_waddr, word_raddr;
  logic [31:0]        word_wdata, word_rdata;
  logic               len_we, len_re;
  logic [SEG_W-1:0]   len_waddr, len_raddr;
  logic [LEN_W-1:0]   len_wdata, len_rdata;
  logic               stk_we, stk_re;
  logic [SEG_W-1:0]   stk_waddr, stk_raddr;
  logic [SEG_W-1:0]   stk_wdata, stk_rdata;

  // Decode helpers
  logic               accept;
  logic               out_free;
  logic               seg_ok;
  logic [SEG_W-1:0]   seg_idx;
  logic [SEG_W-1:0]   map_id;
  logic               map_got;
  logic [AW-1:0]      in_addr;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign seg_ok   = 32'(seg_q) < 32'(SEGMENT_COUNT);
  assign seg_idx  = SEG_W'(seg_q);
  assign in_addr  = AW'(SEG_W'(segment_id_i)) * AW'(SEGMENT_WORDS) + AW'(word_offset_i);

  smm_ram #(.WIDTH(32), .DEPTH(WordDepth)) u_word_ram (
    .clk_i   (clk_i),
    .we_i    (word_we),
    .waddr_i (word_waddr),
    .wdata_i (word_wdata),
    .re_i    (word_re),
    .raddr_i (word_raddr),
    .rdata_o (word_rdata)
  );

  smm_ram #(.WIDTH(LEN_W), .DEPTH(longint'(SEGMENT_COUNT))) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  smm_ram #(.WIDTH(SEG_W), .DEPTH(longint'(SEGMENT_COUNT))) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Sequencer: next state, memory accesses and result
  always_comb begin
    state_d     = state_q;
    clr_idx_d   = clr_idx_q;
    free_cnt_d  = free_cnt_q;
    issued_d    = issued_q;
    base_d      = base_q;
    idx_d       = idx_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    read_word_d = read_word_q;
    mapped_id_d = mapped_id_q;
    status_d    = status_q;

    in_ready_o  = 1'b0;
    word_we     = 1'b0;
    word_waddr  = addr_q;
    word_wdata  = val_q;
    word_re     = 1'b0;
    word_raddr  = in_addr;
    len_we      = 1'b0;
    len_waddr   = seg_idx;
    len_wdata   = '0;
    len_re      = 1'b0;
    len_raddr   = SEG_W'(segment_id_i);
    stk_we      = 1'b0;
    stk_waddr   = SEG_W'(free_cnt_q);
    stk_wdata   = seg_idx;
    stk_re      = 1'b0;
    stk_raddr   = SEG_W'(free_cnt_q - 1'b1);
    map_id      = stk_rdata;
    map_got     = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // zero one length entry per cycle
        len_we    = 1'b1;
        len_waddr = clr_idx_q;
        len_wdata = '0;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == SEG_W'(SEGMENT_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        // launch all reads in the transfer cycle
        word_re = accept;
        len_re  = accept;
        stk_re  = accept;
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_valid_d = 1'b1;
          read_word_d = '0;
          mapped_id_d = '0;
          status_d    = STAT_OK;
          state_d     = ST_IDLE;
          unique case (cmd_q)
            CMD_LOAD: begin
              if (seg_ok && (32'(off_q) < 32'(len_rdata))) begin
                read_word_d = word_rdata;
              end else begin
                status_d = STAT_RANGE;
              end
            end

            CMD_STORE: begin
              if (seg_ok && (32'(off_q) <= 32'(len_rdata)) &&
                  (32'(off_q) < 32'(SEGMENT_WORDS))) begin
                word_we = 1'b1;
                // append grows the segment by one word
                if (32'(off_q) == 32'(len_rdata)) begin
                  len_we    = 1'b1;
                  len_wdata = LEN_W'(off_q) + 1'b1;
                end
              end else begin
                status_d = STAT_RANGE;
              end
            end

            CMD_MAP: begin
              if (32'(words_q) > 32'(SEGMENT_WORDS)) begin
                status_d = STAT_RANGE;
              end else if (free_cnt_q != '0) begin
                // pop the most recently freed ID
                map_id     = stk_rdata;
                map_got    = 1'b1;
                free_cnt_d = free_cnt_q - 1'b1;
              end else if (32'(issued_q) < 32'(SEGMENT_COUNT)) begin
                map_id   = SEG_W'(issued_q);
                map_got  = 1'b1;
                issued_d = issued_q + 1'b1;
              end else begin
                status_d = STAT_NO_ID;
              end
              if (map_got) begin
                mapped_id_d = 6'(map_id);
                len_we      = 1'b1;
                len_waddr   = map_id;
                len_wdata   = LEN_W'(words_q);
                base_d      = AW'(map_id) * AW'(SEGMENT_WORDS);
                n_d         = LEN_W'(words_q);
                idx_d       = '0;
                if (words_q != '0) begin
                  state_d = ST_FILL;
                end
              end
            end

            CMD_UNMAP: begin
              if (!seg_ok) begin
                status_d = STAT_RANGE;
              end else if (32'(free_cnt_q) < 32'(SEGMENT_COUNT)) begin
                // full stack drops the ID silently
                stk_we     = 1'b1;
                free_cnt_d = free_cnt_q + 1'b1;
              end
            end

            CMD_REPLACE: begin
              if (!seg_ok) begin
                status_d = STAT_RANGE;
              end else if (seg_q != '0) begin
                len_we    = 1'b1;
                len_waddr = '0;
                len_wdata = len_rdata;
                base_d    = AW'(seg_idx) * AW'(SEGMENT_WORDS);
                n_d       = len_rdata;
                idx_d     = '0;
                pend_d    = 1'b0;
                state_d   = ST_COPY;
              end
            end

            default: begin
              // unknown command: all-zero result, no effect
            end
          endcase
        end
      end

      ST_FILL: begin
        word_we    = 1'b1;
        word_waddr = base_q + AW'(idx_q);
        word_wdata = '0;
        idx_d      = idx_q + 1'b1;
        if (idx_q + 1'b1 == n_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_COPY: begin
        // read word idx of the source, write it to segment 0 next cycle
        if (pend_q) begin
          word_we    = 1'b1;
          word_waddr = AW'(pend_idx_q);
          word_wdata = word_rdata;
        end
        if (idx_q != n_q) begin
          word_re    = 1'b1;
          word_raddr = base_q + AW'(idx_q);
          idx_d      = idx_q + 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      free_cnt_q  <= '0;
      issued_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      free_cnt_q  <= free_cnt_d;
      issued_q    <= issued_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      seg_q   <= segment_id_i;
      off_q   <= word_offset_i;
      val_q   <= store_value_i;
      words_q <= map_words_i;
      addr_q  <= in_addr;
    end
    base_q      <= base_d;
    idx_q       <= idx_d;
    n_q         <= n_d;
    pend_idx_q  <= pend_idx_d;
    read_word_q <= read_word_d;
    mapped_id_q <= mapped_id_d;
    status_q    <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign read_word_o = read_word_q;
  assign mapped_id_o = mapped_id_q;
  assign status_o    = status_q;

  // Assertions
  a_free_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(free_cnt_q) <= 32'(SEGMENT_COUNT))
    else $error("free ID count exceeds segment count");

  a_issued_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(issued_q) <= 32'(SEGMENT_COUNT))
    else $error("issued ID count exceeds segment count");

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_EXEC)
    else $error("accepted request did not reach execute");

  a_no_write_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_CLEAR) |-> !word_we)
    else $error("word memory written outside a request");

  a_error_result_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (read_word_o == '0 && mapped_id_o == '0))
    else $error("failed request carries nonzero data");

endmodule
